// ===== sv/bccm_pkg.sv =====
// ----------------------------------------------------------------------------
// bccm_pkg
// Shared widths, constants, codes and command/status types for the
// balance cascade motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bccm_pkg;

    // Tuning constants
    localparam int INTEGRAL_MAX     = 16384;
    localparam int INTEGRAL_MIN     = -16384;
    localparam int ENC_COMPENSATION = 0;
    localparam int DEAD_BAND        = 0;

    // Field widths
    localparam int ENC_W     = 12;
    localparam int WORD_W    = 16;
    localparam int LIM_W     = 13;
    localparam int DRV_W     = 14;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int FS_W   = 24;
    localparam int INT_W  = 32;
    localparam int SUM_W  = 14;
    localparam int Q8     = 8;
    localparam int Q16    = 16;
    localparam int MA_W   = 32;
    localparam int MB_W   = 18;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int MIX_W  = ACC_W + 1;

    // Low-pass coefficients (0.7 and 0.3 in Q16) and rounding terms
    localparam int COEF_KEEP  = 45875;
    localparam int COEF_NEW   = 19661;
    localparam int ROUND_HALF = 32768;
    localparam int TRUNC_BIAS = 65535;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_P     = 3'd0,
        REG_SPEED_I     = 3'd1,
        REG_TILT_P      = 3'd2,
        REG_TILT_D      = 3'd3,
        REG_TURN_P      = 3'd4,
        REG_TURN_D      = 3'd5,
        REG_TILT_OFFSET = 3'd6,
        REG_DRIVE_LIMIT = 3'd7
    } reg_idx_t;

    localparam logic [LIM_W-1:0] DRIVE_LIMIT_RESET = 13'd4095;

    typedef struct packed {
        logic signed [WORD_W-1:0] speed_gain_p;
        logic signed [WORD_W-1:0] speed_gain_i;
        logic signed [WORD_W-1:0] tilt_gain_p;
        logic signed [WORD_W-1:0] tilt_gain_d;
        logic signed [WORD_W-1:0] turn_gain_p;
        logic signed [WORD_W-1:0] turn_gain_d;
        logic signed [WORD_W-1:0] tilt_offset;
        logic        [LIM_W-1:0]  drive_limit;
    } cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_KEEP,
        ST_MUL_NEW,
        ST_FILT_ACC,
        ST_FILT_UPD,
        ST_INT_UPD,
        ST_MUL_SP,
        ST_MUL_SI,
        ST_MUL_TP,
        ST_MUL_TD,
        ST_MUL_NP,
        ST_MUL_ND,
        ST_TURN_ACC,
        ST_MIX,
        ST_SAT,
        ST_OUT
    } state_t;

    // Shared multiplier operand select
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_KEEP,
        MUL_NEW,
        MUL_SP,
        MUL_SI,
        MUL_TP,
        MUL_TD,
        MUL_NP,
        MUL_ND
    } mul_sel_t;

    // What happens to last cycle's product
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_TURN_LOAD,
        ACC_TURN_ADD
    } acc_op_t;

    // State and result updates
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_FILTER,
        UPD_INTEGRAL,
        UPD_MIX,
        UPD_SAT
    } upd_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        upd_sel_t upd_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/bccm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bccm_cfg_regs
// Gain, offset and drive limit registers behind the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module bccm_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bccm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bccm_pkg::WORD_W-1:0]    cfg_data,
    output bccm_pkg::cfg_t                 cfg
);
    import bccm_pkg::*;

    // Gains and offset clear, drive limit at its default
    localparam cfg_t CFG_RESET = '{drive_limit: DRIVE_LIMIT_RESET, default: '0};

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SPEED_P:     cfg_next.speed_gain_p = cfg_data;
                REG_SPEED_I:     cfg_next.speed_gain_i = cfg_data;
                REG_TILT_P:      cfg_next.tilt_gain_p  = cfg_data;
                REG_TILT_D:      cfg_next.tilt_gain_d  = cfg_data;
                REG_TURN_P:      cfg_next.turn_gain_p  = cfg_data;
                REG_TURN_D:      cfg_next.turn_gain_d  = cfg_data;
                REG_TILT_OFFSET: cfg_next.tilt_offset  = cfg_data;
                REG_DRIVE_LIMIT: cfg_next.drive_limit  = cfg_data[LIM_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bccm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bccm_ctrl
// Sequencer: steps one control tick through the shared multiplier schedule
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bccm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output bccm_pkg::dp_cmd_t    cmd,
    input  bccm_pkg::dp_status_t status
);
    import bccm_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_HOLD;
        cmd.upd_sel = UPD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_KEEP;
                end
            end
            ST_MUL_KEEP: begin
                cmd.mul_sel = MUL_KEEP;
                state_next  = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                cmd.mul_sel = MUL_NEW;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_FILT_ACC;
            end
            ST_FILT_ACC: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_FILT_UPD;
            end
            ST_FILT_UPD: begin
                cmd.upd_sel = UPD_FILTER;
                state_next  = ST_INT_UPD;
            end
            ST_INT_UPD: begin
                cmd.upd_sel = UPD_INTEGRAL;
                state_next  = ST_MUL_SP;
            end
            ST_MUL_SP: begin
                cmd.mul_sel = MUL_SP;
                state_next  = ST_MUL_SI;
            end
            ST_MUL_SI: begin
                cmd.mul_sel = MUL_SI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_TP;
            end
            ST_MUL_TP: begin
                cmd.mul_sel = MUL_TP;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_MUL_TD;
            end
            ST_MUL_TD: begin
                cmd.mul_sel = MUL_TD;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_MUL_NP;
            end
            ST_MUL_NP: begin
                cmd.mul_sel = MUL_NP;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_MUL_ND;
            end
            ST_MUL_ND: begin
                cmd.mul_sel = MUL_ND;
                cmd.acc_op  = ACC_TURN_LOAD;
                state_next  = ST_TURN_ACC;
            end
            ST_TURN_ACC: begin
                cmd.acc_op = ACC_TURN_ADD;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.upd_sel = UPD_MIX;
                state_next  = ST_SAT;
            end
            ST_SAT: begin
                cmd.upd_sel = UPD_SAT;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous beat is still unclaimed
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Checks
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL_KEEP))
        else $error("accepted beat did not start the multiply schedule");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while holding an unclaimed beat");

    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !status.out_free) |=> (state_reg == ST_OUT))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== sv/bccm_datapath.sv =====
// ----------------------------------------------------------------------------
// bccm_datapath
// Operand registers, one shared 32x18 multiplier, accumulators, filter and
// integral state, mixing/saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bccm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bccm_pkg::cfg_t                      cfg,
    input  bccm_pkg::dp_cmd_t                   cmd,
    output bccm_pkg::dp_status_t                status,
    input  logic signed [bccm_pkg::ENC_W-1:0]   s_left_enc_count,
    input  logic signed [bccm_pkg::ENC_W-1:0]   s_right_enc_count,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_target_speed,
    input  logic                                s_stop_request,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_tilt_angle,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_tilt_rate,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_turn_target,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_yaw_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_left_reverse,
    output logic        [bccm_pkg::DRV_W-1:0]   m_left_drive,
    output logic                                m_right_reverse,
    output logic        [bccm_pkg::DRV_W-1:0]   m_right_drive
);
    import bccm_pkg::*;

    localparam int ANG_W   = WORD_W + 1;
    localparam int SHIFT_W = ACC_W - Q16;
    localparam int WHOLE_W = MIX_W - Q16;
    localparam int ISUM_W  = INT_W + 2;

    localparam logic signed [FS_W-1:0]   FS_MAX = {1'b0, {(FS_W-1){1'b1}}};
    localparam logic signed [FS_W-1:0]   FS_MIN = {1'b1, {(FS_W-1){1'b0}}};
    localparam logic signed [ISUM_W-1:0] INT_HI = ISUM_W'(INTEGRAL_MAX * 256);
    localparam logic signed [ISUM_W-1:0] INT_LO = ISUM_W'(INTEGRAL_MIN * 256);

    // Truncate toward zero by 16 fraction bits, then clamp to +-limit
    function automatic logic signed [DRV_W-1:0] sat_drive(
        input logic signed [MIX_W-1:0] x,
        input logic        [LIM_W-1:0] lim
    );
        logic signed [MIX_W-1:0]   biased;
        logic signed [WHOLE_W-1:0] whole;
        logic signed [WHOLE_W-1:0] lim_pos;
        logic signed [WHOLE_W-1:0] lim_neg;
        biased  = x + (x[MIX_W-1] ? MIX_W'(TRUNC_BIAS) : '0);
        whole   = biased[MIX_W-1:Q16];
        lim_pos = WHOLE_W'({1'b0, lim});
        lim_neg = -lim_pos;
        if (whole > lim_pos) begin
            sat_drive = DRV_W'(lim_pos);
        end else if (whole < lim_neg) begin
            sat_drive = DRV_W'(lim_neg);
        end else begin
            sat_drive = DRV_W'(whole);
        end
    endfunction

    // Operand registers for the current tick
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [WORD_W-1:0] tgt_reg;
    logic                     stop_reg;
    logic signed [ANG_W-1:0]  ang_diff_reg;
    logic signed [WORD_W-1:0] trate_reg;
    logic signed [WORD_W-1:0] tturn_reg;
    logic signed [WORD_W-1:0] yaw_reg;

    // Loop state
    logic signed [FS_W-1:0]  fs_reg;
    logic signed [FS_W-1:0]  fs_next;
    logic signed [INT_W-1:0] integ_reg;
    logic signed [INT_W-1:0] integ_next;

    // Arithmetic
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  turn_reg;
    logic signed [MIX_W-1:0]  mix_l_reg;
    logic signed [MIX_W-1:0]  mix_r_reg;
    logic signed [DRV_W-1:0]  sat_l_reg;
    logic signed [DRV_W-1:0]  sat_r_reg;

    logic signed [SUM_W+Q8-1:0]  sum_q8;
    logic signed [WORD_W+Q8-1:0] tgt_q8;
    logic signed [WORD_W+Q8-1:0] trate_q8;
    logic signed [WORD_W+Q8-1:0] tturn_q8;
    logic signed [WORD_W+Q8-1:0] yaw_q8;
    logic signed [ACC_W-1:0]     fs_round;
    logic signed [SHIFT_W-1:0]   fs_shift;
    logic signed [ISUM_W-1:0]    int_sum;

    logic                    m_valid_reg;
    logic                    m_left_reverse_reg;
    logic [DRV_W-1:0]        m_left_drive_reg;
    logic                    m_right_reverse_reg;
    logic [DRV_W-1:0]        m_right_drive_reg;
    logic signed [DRV_W-1:0] abs_l;
    logic signed [DRV_W-1:0] abs_r;

    assign sum_q8   = {sum_reg, {Q8{1'b0}}};
    assign tgt_q8   = {tgt_reg, {Q8{1'b0}}};
    assign trate_q8 = {trate_reg, {Q8{1'b0}}};
    assign tturn_q8 = {tturn_reg, {Q8{1'b0}}};
    assign yaw_q8   = {yaw_reg, {Q8{1'b0}}};

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sum_reg      <= SUM_W'(s_left_enc_count) + SUM_W'(s_right_enc_count)
                            + SUM_W'(ENC_COMPENSATION);
            tgt_reg      <= s_target_speed;
            stop_reg     <= s_stop_request;
            ang_diff_reg <= ANG_W'(s_tilt_angle) - ANG_W'(cfg.tilt_offset);
            trate_reg    <= s_tilt_rate;
            tturn_reg    <= s_turn_target;
            yaw_reg      <= s_yaw_rate;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_KEEP: begin
                mul_a = MA_W'(fs_reg);
                mul_b = MB_W'(COEF_KEEP);
            end
            MUL_NEW: begin
                mul_a = MA_W'(sum_q8);
                mul_b = MB_W'(COEF_NEW);
            end
            MUL_SP: begin
                mul_a = MA_W'(fs_reg);
                mul_b = MB_W'(cfg.speed_gain_p);
            end
            MUL_SI: begin
                mul_a = MA_W'(integ_reg);
                mul_b = MB_W'(cfg.speed_gain_i);
            end
            MUL_TP: begin
                mul_a = MA_W'(ang_diff_reg);
                mul_b = MB_W'(cfg.tilt_gain_p);
            end
            MUL_TD: begin
                mul_a = MA_W'(trate_q8);
                mul_b = MB_W'(cfg.tilt_gain_d);
            end
            MUL_NP: begin
                mul_a = MA_W'(tturn_q8);
                mul_b = MB_W'(cfg.turn_gain_p);
            end
            MUL_ND: begin
                mul_a = MA_W'(yaw_q8);
                mul_b = MB_W'(cfg.turn_gain_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Accumulators: speed minus tilt in acc, turn term on its own
    always_ff @(posedge aclk) begin
        unique case (cmd.acc_op)
            ACC_HOLD:      ;
            ACC_LOAD:      acc_reg  <= ACC_W'(prod_reg);
            ACC_ADD:       acc_reg  <= acc_reg + ACC_W'(prod_reg);
            ACC_SUB:       acc_reg  <= acc_reg - ACC_W'(prod_reg);
            ACC_TURN_LOAD: turn_reg <= ACC_W'(prod_reg);
            ACC_TURN_ADD:  turn_reg <= turn_reg + ACC_W'(prod_reg);
            default:       ;
        endcase
    end

    // Filter update: round half up, drop 16 fraction bits, clamp to 24 bits
    always_comb begin
        fs_round = acc_reg + ACC_W'(ROUND_HALF);
        fs_shift = fs_round[ACC_W-1:Q16];
        if (fs_shift > SHIFT_W'(FS_MAX)) begin
            fs_next = FS_MAX;
        end else if (fs_shift < SHIFT_W'(FS_MIN)) begin
            fs_next = FS_MIN;
        end else begin
            fs_next = FS_W'(fs_shift);
        end
    end

    // Integral update with clamping
    always_comb begin
        int_sum = ISUM_W'(integ_reg) + ISUM_W'(fs_reg) - ISUM_W'(tgt_q8);
        if (int_sum > INT_HI) begin
            integ_next = INT_W'(INT_HI);
        end else if (int_sum < INT_LO) begin
            integ_next = INT_W'(INT_LO);
        end else begin
            integ_next = INT_W'(int_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= '0;
            integ_reg <= '0;
        end else begin
            if (cmd.upd_sel == UPD_FILTER) begin
                fs_reg <= fs_next;
            end
            if (cmd.upd_sel == UPD_INTEGRAL) begin
                integ_reg <= integ_next;
            end else if (cmd.out_load && stop_reg) begin
                // stop clears the integral once this tick's result is out
                integ_reg <= '0;
            end
        end
    end

    // Per-wheel mix, then truncate and saturate
    always_ff @(posedge aclk) begin
        if (cmd.upd_sel == UPD_MIX) begin
            mix_l_reg <= MIX_W'(acc_reg) + MIX_W'(turn_reg);
            mix_r_reg <= MIX_W'(acc_reg) - MIX_W'(turn_reg);
        end
        if (cmd.upd_sel == UPD_SAT) begin
            sat_l_reg <= sat_drive(mix_l_reg, cfg.drive_limit);
            sat_r_reg <= sat_drive(mix_r_reg, cfg.drive_limit);
        end
    end

    // Direction and magnitude plus dead band
    assign abs_l = sat_l_reg[DRV_W-1] ? -sat_l_reg : sat_l_reg;
    assign abs_r = sat_r_reg[DRV_W-1] ? -sat_r_reg : sat_r_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_left_reverse_reg  <= sat_l_reg[DRV_W-1];
            m_left_drive_reg    <= DRV_W'(abs_l) + DRV_W'(DEAD_BAND);
            m_right_reverse_reg <= sat_r_reg[DRV_W-1];
            m_right_drive_reg   <= DRV_W'(abs_r) + DRV_W'(DEAD_BAND);
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_left_reverse  = m_left_reverse_reg;
    assign m_left_drive    = m_left_drive_reg;
    assign m_right_reverse = m_right_reverse_reg;
    assign m_right_drive   = m_right_drive_reg;

    // Checks
    a_integ_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ISUM_W'(integ_reg) <= INT_HI) && (ISUM_W'(integ_reg) >= INT_LO))
        else $error("speed integral outside its clamp window");

    a_fs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd_sel != UPD_FILTER) |=> $stable(fs_reg))
        else $error("filtered speed changed outside the filter step");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== sv/balance_cascade_motor_controller.sv =====
// ----------------------------------------------------------------------------
// balance_cascade_motor_controller
// Two-wheel balance controller: speed PI, tilt PD and turn PD loops mixed
// into a direction and drive magnitude per wheel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one beat per control tick (encoder counts, speed
//   target, stop request, tilt angle/rate, turn target, yaw rate).
//   Result channel m_*: one beat per tick (direction and magnitude per wheel).
//   Config channel cfg_*: writes gains, tilt offset and drive limit by index;
//   always ready. Write only while no tick is in flight.
//   Schedule: a tick steps through the eight products that share one
//   32x18 multiplier plus the filter, integral, mix and saturate steps. The
//   result is registered as the sequencer leaves ST_OUT and s_ready rises at that
//   same edge, so a new beat is taken only once the previous result is loaded.
//   Stall: while m_valid waits for m_ready the next tick is still accepted
//   and computed; it then waits in the sequencer for the output register.
//   Reset (aresetn low, synchronous): filter state and integral clear, gains
//   and offset clear, drive limit returns to 4095, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_cascade_motor_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bccm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bccm_pkg::WORD_W-1:0]         cfg_data,
    // tick input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bccm_pkg::ENC_W-1:0]   s_left_enc_count,
    input  logic signed [bccm_pkg::ENC_W-1:0]   s_right_enc_count,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_target_speed,
    input  logic                                s_stop_request,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_tilt_angle,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_tilt_rate,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_turn_target,
    input  logic signed [bccm_pkg::WORD_W-1:0]  s_yaw_rate,
    // drive result
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_left_reverse,
    output logic        [bccm_pkg::DRV_W-1:0]   m_left_drive,
    output logic                                m_right_reverse,
    output logic        [bccm_pkg::DRV_W-1:0]   m_right_drive
);
    import bccm_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    bccm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bccm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    bccm_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .s_left_enc_count  (s_left_enc_count),
        .s_right_enc_count (s_right_enc_count),
        .s_target_speed    (s_target_speed),
        .s_stop_request    (s_stop_request),
        .s_tilt_angle      (s_tilt_angle),
        .s_tilt_rate       (s_tilt_rate),
        .s_turn_target     (s_turn_target),
        .s_yaw_rate        (s_yaw_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_reverse    (m_left_reverse),
        .m_left_drive      (m_left_drive),
        .m_right_reverse   (m_right_reverse),
        .m_right_drive     (m_right_drive)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the balance cascade motor controller. A scoreboard
// class carries its own copy of the speed filter, the speed integral and the
// gain registers. It predicts both wheel drive beats for every accepted tick
// and compares each returned beat field by field.
// Stimulus is a short directed set (field extremes, stop requests, integral
// clamping, turn-only and zero-drive ticks). It is followed by random phases
// under several gain settings, including the all-max, all-min and zero-limit
// extremes. The sender runs in random bursts, the receiver stalls on its own
// pattern, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bccm_pkg::*;

    localparam int     HALF_PERIOD = 5;
    localparam int     RESET_CYCLES = 7;
    localparam int     SETTLE_CYCLES = 20;    // quiet time after the last drive beat
    localparam int     TAIL_CYCLES = 40;
    localparam int     HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int     WATCHDOG_LIMIT = 3000; // cycles with no handshake at all
    localparam int     MAX_REPORTS = 50;
    localparam longint FILT_MAX = 64'sd8388607;
    localparam longint FILT_MIN = -64'sd8388608;
    localparam longint INTEG_MAX = longint'(INTEGRAL_MAX) * 256;
    localparam longint INTEG_MIN = longint'(INTEGRAL_MIN) * 256;

    typedef enum int {
        SET_DIRECTED,
        SET_MAX,
        SET_MIN,
        SET_MODEST,
        SET_WILD,
        SET_NO_DRIVE
    } setting_kind_t;

    typedef struct {
        logic signed [ENC_W-1:0]  left_enc;
        logic signed [ENC_W-1:0]  right_enc;
        logic signed [WORD_W-1:0] target;
        logic                     stop;
        logic signed [WORD_W-1:0] angle;
        logic signed [WORD_W-1:0] rate;
        logic signed [WORD_W-1:0] turn;
        logic signed [WORD_W-1:0] yaw;
    } tick_t;

    typedef struct {
        logic             left_rev;
        logic [DRV_W-1:0] left_drv;
        logic             right_rev;
        logic [DRV_W-1:0] right_drv;
    } drive_t;

    // ------------------------------------------------------------------------
    // Drive predictor and beat checker
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        longint gain [8];
        longint filt_speed;
        longint integ;
        drive_t drive_q [$];
        int     mismatches;
        int     checked;
        int     ticks;
        int     stops;
        int     clipped;

        function new();
            int i;
            for (i = 0; i < 8; i++) gain[i] = 0;
            gain[REG_DRIVE_LIMIT] = longint'(DRIVE_LIMIT_RESET);
            filt_speed = 0;
            integ = 0;
            mismatches = 0;
            checked = 0;
            ticks = 0;
            stops = 0;
            clipped = 0;
        endfunction

        function void write_reg(input reg_idx_t idx, input logic [WORD_W-1:0] data);
            if (idx == REG_DRIVE_LIMIT) begin
                gain[idx] = longint'(data[LIM_W-1:0]);
            end else begin
                gain[idx] = longint'($signed(data));
            end
        endfunction

        function longint clip(input longint x, input longint lo, input longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        // drop 16 fraction bits, rounding toward zero
        function longint drop_frac(input longint x);
            if (x >= 0) return x >>> 16;
            return -((-x) >>> 16);
        endfunction

        function void to_drive(input longint v, output logic rev,
                               output logic [DRV_W-1:0] mag);
            longint m;
            rev = (v < 0);
            m = (v < 0) ? -v : v;
            m = m + DEAD_BAND;
            mag = m[DRV_W-1:0];
        endfunction

        function void note_tick(input tick_t t);
            longint sum, acc, speed_q, tilt_q, turn_q, lv, rv, lraw, rraw, lim;
            drive_t d;
            ticks++;
            if (t.stop) stops++;

            // speed loop: low-pass, then clamped integral
            sum = longint'(t.left_enc) + longint'(t.right_enc) + ENC_COMPENSATION;
            acc = filt_speed * COEF_KEEP + sum * 256 * COEF_NEW + ROUND_HALF;
            filt_speed = clip(acc >>> 16, FILT_MIN, FILT_MAX);
            integ = clip(integ + filt_speed - longint'(t.target) * 256,
                         INTEG_MIN, INTEG_MAX);

            speed_q = filt_speed * gain[REG_SPEED_P] + integ * gain[REG_SPEED_I];
            tilt_q = gain[REG_TILT_P] * (longint'(t.angle) - gain[REG_TILT_OFFSET])
                   + gain[REG_TILT_D] * longint'(t.rate) * 256;
            turn_q = (gain[REG_TURN_P] * longint'(t.turn)
                   + gain[REG_TURN_D] * longint'(t.yaw)) * 256;

            // per-wheel mix and saturation
            lim = gain[REG_DRIVE_LIMIT];
            lraw = drop_frac(-tilt_q + speed_q + turn_q);
            rraw = drop_frac(-tilt_q + speed_q - turn_q);
            lv = clip(lraw, -lim, lim);
            rv = clip(rraw, -lim, lim);
            if (lv != lraw || rv != rraw) clipped++;
            to_drive(lv, d.left_rev, d.left_drv);
            to_drive(rv, d.right_rev, d.right_drv);
            drive_q.push_back(d);

            // stop clears the integral after this tick's result
            if (t.stop) integ = 0;
        endfunction

        task report_mismatch(input string what, input longint got, input longint want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR beat %0d: %s got %0d, expected %0d",
                         checked, what, got, want);
        endtask

        task check_result(input drive_t got);
            drive_t want;
            if (drive_q.size() == 0) begin
                report_mismatch("drive beat with no tick outstanding", 1, 0);
            end else begin
                want = drive_q.pop_front();
                if (got.left_rev !== want.left_rev)
                    report_mismatch("left_reverse", got.left_rev, want.left_rev);
                if (got.left_drv !== want.left_drv)
                    report_mismatch("left_drive", got.left_drv, want.left_drv);
                if (got.right_rev !== want.right_rev)
                    report_mismatch("right_reverse", got.right_rev, want.right_rev);
                if (got.right_drv !== want.right_drv)
                    report_mismatch("right_drive", got.right_drv, want.right_drv);
            end
            checked++;
        endtask

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [ENC_W-1:0]  s_left_enc_count;
    logic signed [ENC_W-1:0]  s_right_enc_count;
    logic signed [WORD_W-1:0] s_target_speed;
    logic                     s_stop_request;
    logic signed [WORD_W-1:0] s_tilt_angle;
    logic signed [WORD_W-1:0] s_tilt_rate;
    logic signed [WORD_W-1:0] s_turn_target;
    logic signed [WORD_W-1:0] s_yaw_rate;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_left_reverse;
    logic [DRV_W-1:0]         m_left_drive;
    logic                     m_right_reverse;
    logic [DRV_W-1:0]         m_right_drive;

    balance_cascade_motor_controller dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_left_enc_count  (s_left_enc_count),
        .s_right_enc_count (s_right_enc_count),
        .s_target_speed    (s_target_speed),
        .s_stop_request    (s_stop_request),
        .s_tilt_angle      (s_tilt_angle),
        .s_tilt_rate       (s_tilt_rate),
        .s_turn_target     (s_turn_target),
        .s_yaw_rate        (s_yaw_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_reverse    (m_left_reverse),
        .m_left_drive      (m_left_drive),
        .m_right_reverse   (m_right_reverse),
        .m_right_drive     (m_right_drive)
    );

    drive_scoreboard   book = new();
    logic [WORD_W-1:0] setting [8];
    int                burst_left = 0;
    int                cruise = 0;
    int                settings_loaded = 0;
    int                holds_done = 0;
    int                idle_cycles = 0;
    bit                hold_req = 0;

    // Clock
    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------------
    // Config writes: only called while no tick is in flight
    // ------------------------------------------------------------------------
    task automatic load_setting(input setting_kind_t kind);
        int       i;
        reg_idx_t idx;
        for (i = 0; i < 8; i++) begin
            idx = reg_idx_t'(i);
            case (kind)
                SET_DIRECTED: begin
                    setting[REG_SPEED_P]     = 16'h0100;
                    setting[REG_SPEED_I]     = 16'h0004;
                    setting[REG_TILT_P]      = 16'h0400;
                    setting[REG_TILT_D]      = 16'h0020;
                    setting[REG_TURN_P]      = 16'h0080;
                    setting[REG_TURN_D]      = 16'hFFC0;
                    setting[REG_TILT_OFFSET] = 16'h0180;
                    setting[REG_DRIVE_LIMIT] = 16'd4095;
                end
                SET_MAX: begin
                    setting[idx] = (idx == REG_TILT_OFFSET) ? 16'h8000 : 16'h7FFF;
                    if (idx == REG_DRIVE_LIMIT) setting[idx] = 16'd8191;
                end
                SET_MIN: begin
                    setting[idx] = (idx == REG_TILT_OFFSET) ? 16'h7FFF : 16'h8000;
                    if (idx == REG_DRIVE_LIMIT) setting[idx] = 16'd8191;
                end
                SET_WILD: begin
                    setting[idx] = WORD_W'($urandom());
                end
                default: begin
                    // modest gains keep most drive values inside the limit
                    setting[idx] = WORD_W'(int'($urandom_range(0, 2048)) - 1024);
                    if (idx == REG_TILT_OFFSET)
                        setting[idx] = WORD_W'(int'($urandom_range(0, 4000)) - 2000);
                end
            endcase
            if (idx == REG_DRIVE_LIMIT && (kind == SET_MODEST || kind == SET_WILD))
                setting[idx] = WORD_W'($urandom_range(0, 8191));
            if (idx == REG_DRIVE_LIMIT && kind == SET_NO_DRIVE)
                setting[idx] = 16'd0;

            @(negedge aclk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = setting[idx];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            book.write_reg(idx, setting[idx]);
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Tick sender: random bursts with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_left_enc_count  = t.left_enc;
        s_right_enc_count = t.right_enc;
        s_target_speed    = t.target;
        s_stop_request    = t.stop;
        s_tilt_angle      = t.angle;
        s_tilt_rate       = t.rate;
        s_turn_target     = t.turn;
        s_yaw_rate        = t.yaw;
        s_valid           = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.note_tick(t);
    endtask

    // Drop valid and wait until every drive beat is back and the block is quiet
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic tick_t mk(input int l, input int r, input int tgt, input int stp,
                                 input int ang, input int rate, input int turn,
                                 input int yaw);
        tick_t t;
        t.left_enc  = ENC_W'(l);
        t.right_enc = ENC_W'(r);
        t.target    = WORD_W'(tgt);
        t.stop      = stp[0];
        t.angle     = WORD_W'(ang);
        t.rate      = WORD_W'(rate);
        t.turn      = WORD_W'(turn);
        t.yaw       = WORD_W'(yaw);
        return t;
    endfunction

    // Mostly plausible ticks around a drifting cruise speed, some pure noise
    function automatic tick_t random_tick();
        tick_t t;
        int    l, r, centre;
        if ($urandom_range(0, 3) == 0) begin
            t.left_enc  = ENC_W'($urandom());
            t.right_enc = ENC_W'($urandom());
            t.target    = WORD_W'($urandom());
            t.stop      = 1'($urandom_range(0, 1));
            t.angle     = WORD_W'($urandom());
            t.rate      = WORD_W'($urandom());
            t.turn      = WORD_W'($urandom());
            t.yaw       = WORD_W'($urandom());
        end else begin
            if ($urandom_range(0, 31) == 0) cruise = int'($urandom_range(0, 1600)) - 800;
            centre = int'($signed(setting[REG_TILT_OFFSET]));
            l = cruise + int'($urandom_range(0, 40)) - 20;
            r = cruise + int'($urandom_range(0, 40)) - 20;
            t.left_enc  = ENC_W'(l);
            t.right_enc = ENC_W'(r);
            t.target    = WORD_W'(l + r + int'($urandom_range(0, 20)) - 10);
            t.stop      = ($urandom_range(0, 15) == 0);
            t.angle     = WORD_W'(centre + int'($urandom_range(0, 1024)) - 512);
            t.rate      = WORD_W'(int'($urandom_range(0, 4000)) - 2000);
            t.turn      = WORD_W'(int'($urandom_range(0, 2000)) - 1000);
            t.yaw       = WORD_W'(int'($urandom_range(0, 2000)) - 1000);
        end
        return t;
    endfunction

    task automatic random_phase(input setting_kind_t kind, input int count, input bit hold);
        int n;
        load_setting(kind);
        if (hold) hold_req = 1'b1;
        for (n = 0; n < count; n++) send_tick(random_tick());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int span;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        drive_t got;
        if (aresetn && m_valid && m_ready) begin
            got.left_rev  = m_left_reverse;
            got.left_drv  = m_left_drive;
            got.right_rev = m_right_reverse;
            got.right_drv = m_right_drive;
            book.check_result(got);
        end
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d beats outstanding",
                     idle_cycles, book.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int n;
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_left_enc_count  = '0;
        s_right_enc_count = '0;
        s_target_speed    = '0;
        s_stop_request    = 1'b0;
        s_tilt_angle      = '0;
        s_tilt_rate       = '0;
        s_turn_target     = '0;
        s_yaw_rate        = '0;
        for (n = 0; n < 8; n++) setting[n] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset gains: every tick must give zero drive, forward
        send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(mk(2047, 2047, 32767, 1, 32767, 32767, 32767, 32767));
        drain();

        // directed ticks under a known gain set
        load_setting(SET_DIRECTED);
        send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(mk(2047, 2047, 32767, 0, 32767, 32767, 32767, 32767));
        send_tick(mk(-2048, -2048, -32768, 0, -32768, -32768, -32768, -32768));
        send_tick(mk(100, 100, 200, 1, 384, 0, 0, 0));
        send_tick(mk(100, 100, 200, 0, 384, 0, 0, 0));
        // drive the integral into both clamps
        repeat (5) send_tick(mk(2047, 2047, -32768, 0, 384, 0, 0, 0));
        repeat (5) send_tick(mk(-2048, -2048, 32767, 0, 384, 0, 0, 0));
        send_tick(mk(0, 0, 0, 1, 384, 0, 1000, 0));
        send_tick(mk(0, 0, 0, 0, 384, 0, 0, -1000));
        send_tick(mk(0, 0, 0, 0, 384, 0, 0, 0));
        send_tick(mk(0, 0, 0, 0, 385, 1, 0, 0));
        drain();

        // random phases across gain settings; the first one backs the block up
        random_phase(SET_MODEST, 180, 1'b1);
        random_phase(SET_MAX, 65, 1'b0);
        random_phase(SET_MODEST, 180, 1'b0);
        random_phase(SET_MIN, 65, 1'b0);
        random_phase(SET_WILD, 65, 1'b0);
        random_phase(SET_NO_DRIVE, 65, 1'b0);
        random_phase(SET_MODEST, 180, 1'b0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d ticks (%0d with stop) over %0d gain settings, %0d long hold-offs.",
                 book.ticks, book.stops, settings_loaded, holds_done);
        $display("Checked %0d drive beats, %0d with a wheel at the drive limit.",
                 book.checked, book.clipped);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/bccm_pkg.sv
sv/bccm_cfg_regs.sv
sv/bccm_ctrl.sv
sv/bccm_datapath.sv
sv/balance_cascade_motor_controller.sv
sim/tb_top.sv
